/* rtl/core/vdu_pkg.sv */
// Shared types, constants and state codes of the vector distance unit.
package vdu_pkg;

  localparam int ELEM_FIELD_W   = 16;
  localparam int ELEMENT_WIDTH  = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int SUM_W          = 48;
  localparam int ROOT_W         = SUM_W / 2;
  localparam int REM_W          = ROOT_W + 2;
  localparam int STEP_W         = $clog2(ROOT_W);
  localparam int METRIC_W       = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Metric register codes; the unused code behaves as squared Euclidean.
  localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_SQ_EUCLID = 2'd2;

  typedef struct packed {
    logic signed [ELEM_FIELD_W-1:0] a_elem;
    logic signed [ELEM_FIELD_W-1:0] b_elem;
    logic                           last;
  } vdu_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] distance;
    logic             saturated;
  } vdu_out_t;

  // One finished vector, handed from the accumulator to the result stage.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
    logic             root;
  } vdu_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_HOLD
  } vdu_back_state_t;

endpackage

/* rtl/core/vdu_front.sv */
// Front end: difference, magnitude, square (all metrics but Manhattan) and saturating accumulation per pair.
module vdu_front #(
  parameter int ELEMENT_WIDTH = vdu_pkg::ELEMENT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  vdu_pkg::vdu_in_t              in_data,
  input  logic [vdu_pkg::METRIC_W-1:0]  metric,
  output logic                          job_push,
  output vdu_pkg::vdu_job_t             job,
  output logic [1:0]                    pending_last
);

  localparam int EW    = ELEMENT_WIDTH;
  localparam int SUM_W = vdu_pkg::SUM_W;

  logic signed [EW-1:0] a_s;
  logic signed [EW-1:0] b_s;
  logic signed [EW:0]   diff;
  logic [EW:0]          mag_full;

  // stage 1: magnitude of the difference
  logic          s1_valid;
  logic [EW-1:0] s1_mag;
  logic          s1_sq;
  logic          s1_root;
  logic          s1_last;

  // stage 2: term to accumulate
  logic            s2_valid;
  logic [2*EW-1:0] s2_term;
  logic            s2_root;
  logic            s2_last;
  logic [2*EW-1:0] term_next;

  // stage 3: running sum
  logic [SUM_W-1:0] running_sum;
  logic             overflow_seen;
  logic [SUM_W:0]   add_full;
  logic [SUM_W-1:0] sum_next;
  logic             ovf_next;

  assign a_s      = in_data.a_elem[EW-1:0];
  assign b_s      = in_data.b_elem[EW-1:0];
  assign diff     = {a_s[EW-1], a_s} - {b_s[EW-1], b_s};
  assign mag_full = diff[EW] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    if (in_fire) begin
      s1_mag  <= mag_full[EW-1:0];
      s1_sq   <= (metric != vdu_pkg::METRIC_MANHATTAN);
      s1_root <= (metric == vdu_pkg::METRIC_EUCLID);
      s1_last <= in_data.last;
    end
  end

  assign term_next = s1_sq ? s1_mag * s1_mag : {{EW{1'b0}}, s1_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_term <= term_next;
      s2_root <= s1_root;
      s2_last <= s1_last;
    end
  end

  assign add_full = {1'b0, running_sum} + {{(SUM_W+1-2*EW){1'b0}}, s2_term};
  assign sum_next = add_full[SUM_W] ? vdu_pkg::SUM_MAX : add_full[SUM_W-1:0];
  assign ovf_next = overflow_seen | add_full[SUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
    end else if (s2_valid) begin
      if (s2_last) begin
        running_sum   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        running_sum   <= sum_next;
        overflow_seen <= ovf_next;
      end
    end
  end

  assign job_push     = s2_valid & s2_last;
  assign job.sum      = sum_next;
  assign job.ovf      = ovf_next;
  assign job.root     = s2_root;
  assign pending_last = {1'b0, s1_valid & s1_last} + {1'b0, s2_valid & s2_last};

endmodule

/* rtl/core/vdu_queue.sv */
// Short job queue between the accumulator and the result stage.
module vdu_queue #(
  parameter int QUEUE_DEPTH = vdu_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  vdu_pkg::vdu_job_t                push_data,
  input  logic                             pop,
  output vdu_pkg::vdu_job_t                head,
  output logic                             empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH+1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  vdu_pkg::vdu_job_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

endmodule

/* rtl/core/vdu_back.sv */
// Result stage: optional bit-serial square root and the output register.
module vdu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  vdu_pkg::vdu_job_t    head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vdu_pkg::vdu_out_t    out_data
);

  localparam int SUM_W  = vdu_pkg::SUM_W;
  localparam int ROOT_W = vdu_pkg::ROOT_W;
  localparam int REM_W  = vdu_pkg::REM_W;
  localparam int STEP_W = vdu_pkg::STEP_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

  vdu_pkg::vdu_back_state_t state, state_next;

  logic [SUM_W-1:0]  radicand;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;
  logic              ovf;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;
  logic [ROOT_W-1:0] root_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdu_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      vdu_pkg::BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = head.root ? vdu_pkg::BK_ROOT : vdu_pkg::BK_HOLD;
        end
      end
      vdu_pkg::BK_ROOT: begin
        if (step == LAST_STEP) begin
          state_next = vdu_pkg::BK_HOLD;
        end
      end
      vdu_pkg::BK_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = vdu_pkg::BK_IDLE;
        end
      end
      default: state_next = vdu_pkg::BK_IDLE;
    endcase
  end

  // one result bit per cycle, two radicand bits brought down each step
  assign rem_sh    = {rem[REM_W-3:0], radicand[SUM_W-1:SUM_W-2]};
  assign trial     = {root, 2'b01};
  assign take      = (rem_sh >= trial);
  assign root_next = {root[ROOT_W-2:0], take};

  always_ff @(posedge clk) begin
    unique case (state)
      vdu_pkg::BK_IDLE: begin
        radicand <= head.sum;
        ovf      <= head.ovf;
        rem      <= '0;
        root     <= '0;
        step     <= '0;
        if (!empty && !head.root) begin
          out_data.distance  <= head.sum;
          out_data.saturated <= head.ovf;
        end
      end
      vdu_pkg::BK_ROOT: begin
        radicand <= {radicand[SUM_W-3:0], 2'b00};
        rem      <= take ? rem_sh - trial : rem_sh;
        root     <= root_next;
        step     <= step + 1'b1;
        if (step == LAST_STEP) begin
          out_data.distance  <= {{(SUM_W-ROOT_W){1'b0}}, root_next};
          out_data.saturated <= ovf;
        end
      end
      default: begin
        radicand <= radicand;
      end
    endcase
  end

endmodule

/* rtl/core/vector_distance_unit.sv */
// Top level of the vector distance unit: metric register, front end, job queue, result stage.
//
// Vectors stream in as one coordinate pair per transfer, the final pair flagged by last.
// The front end takes one pair every cycle while in_ready is high: it forms |a-b| or (a-b)^2
// under the metric in force when the pair is accepted and adds it into a 48-bit sum that clamps
// at 2^48-1 and sets saturated. On the last pair, after the stage 1 and stage 2 registers, the
// finished sum enters a queue of QUEUE_DEPTH jobs. The result stage drains the queue: squared
// Euclidean and Manhattan results go from IDLE to HOLD, a square root runs through ROOT first
// (one root bit per cycle from a shared compare-and-subtract step, 24 steps), and a new job is
// taken only after the last result leaves HOLD. Input transfers stall only while the queue
// together with the final pairs still in the front pipeline fills all QUEUE_DEPTH slots.
// Write the metric (0 Manhattan, 1 Euclidean, 2 or 3 squared Euclidean) only while idle.
module vector_distance_unit #(
  parameter int ELEMENT_WIDTH = vdu_pkg::ELEMENT_WIDTH,
  parameter int QUEUE_DEPTH   = vdu_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vdu_pkg::vdu_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vdu_pkg::vdu_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [vdu_pkg::METRIC_W-1:0] cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [vdu_pkg::METRIC_W-1:0] metric;
  logic                         in_fire;
  logic                         job_push;
  logic                         job_pop;
  vdu_pkg::vdu_job_t            job;
  vdu_pkg::vdu_job_t            head;
  logic                         q_empty;
  logic [CW-1:0]                q_count;
  logic [1:0]                   pending_last;
  logic [CW:0]                  committed;

  // metric register; the user must write it only between vectors, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= vdu_pkg::METRIC_MANHATTAN;
    end else if (cfg_we) begin
      metric <= cfg_data;
    end
  end

  // reserve a queue slot for every final pair still in the front pipeline
  assign committed = {1'b0, q_count} + {{(CW-1){1'b0}}, pending_last};
  assign in_ready  = (committed < (CW+1)'(QUEUE_DEPTH));
  assign in_fire   = in_valid & in_ready;

  vdu_front #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .in_data      (in_data),
    .metric       (metric),
    .job_push     (job_push),
    .job          (job),
    .pending_last (pending_last)
  );

  vdu_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job),
    .pop       (job_pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  vdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the credit check must keep the queue from ever taking a job while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push && !job_pop |-> (q_count < CW'(QUEUE_DEPTH)))
    else $error("job queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("job queue count out of range");

  // a job without a root shows up unchanged in the output register
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    job_pop && !head.root |=> out_valid && (out_data.distance == $past(head.sum))
      && (out_data.saturated == $past(head.ovf)))
    else $error("pass-through result does not match its job");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the vector distance unit: directed table, a back-pressure phase and random vectors.
module testbench;

  // The spare metric code decodes as squared Euclidean.
  localparam logic [vdu_pkg::METRIC_W-1:0] METRIC_UNUSED = 2'd3;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  // Front pipeline plus a full square root, with margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_PAIRS  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_VECTORS = 40;
  localparam longint TIMEOUT  = 64'd1_500_000 * 2 * CLK_HALF;

  typedef struct {
    logic                         wr_metric;
    logic [vdu_pkg::METRIC_W-1:0] metric;
    vdu_pkg::vdu_in_t             pair;
    logic                         known;
    vdu_pkg::vdu_out_t            want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  vdu_pkg::vdu_in_t             in_data;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  vdu_pkg::vdu_out_t            out_data;
  logic                         cfg_we;
  logic [vdu_pkg::METRIC_W-1:0] cfg_data;

  // Predictor state: mirrors the metric register and the running accumulator.
  logic [vdu_pkg::METRIC_W-1:0] metric_now;
  logic [63:0]                  acc_sum;
  logic                         acc_ovf;

  vdu_pkg::vdu_out_t pending_results[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  // Toggle hold_req to ask the receiver for one long hold-off.
  logic     hold_req = 1'b0;
  logic     hold_ack = 1'b0;

  vector_distance_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Bit-serial floor square root of a 48-bit sum.
  function automatic logic [vdu_pkg::ROOT_W-1:0] int_root(
    input logic [vdu_pkg::SUM_W-1:0] x);
    logic [vdu_pkg::ROOT_W-1:0] r;
    logic [vdu_pkg::ROOT_W-1:0] t;
    r = '0;
    for (int i = vdu_pkg::ROOT_W - 1; i >= 0; i--) begin
      t = r | (vdu_pkg::ROOT_W'(1) << i);
      if (vdu_pkg::SUM_W'(t) * vdu_pkg::SUM_W'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Fold one coordinate pair into the accumulator; return 1 with the distance on a last pair.
  function automatic logic fold_pair(input vdu_pkg::vdu_in_t p,
                                     output vdu_pkg::vdu_out_t res);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [63:0]        term;
    logic [63:0]        total;
    diff = p.a_elem - p.b_elem;
    mag = (diff < 0) ? -diff : diff;
    term = mag;
    if (metric_now != vdu_pkg::METRIC_MANHATTAN) term = term * term;
    total = acc_sum + term;
    if (total > {16'd0, vdu_pkg::SUM_MAX}) begin
      acc_sum = {16'd0, vdu_pkg::SUM_MAX};
      acc_ovf = 1'b1;
    end else begin
      acc_sum = total;
    end
    res = '0;
    if (!p.last) return 1'b0;
    res.distance  = (metric_now == vdu_pkg::METRIC_EUCLID)
                  ? vdu_pkg::SUM_W'(int_root(acc_sum[vdu_pkg::SUM_W-1:0]))
                  : acc_sum[vdu_pkg::SUM_W-1:0];
    res.saturated = acc_ovf;
    acc_sum = '0;
    acc_ovf = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t mk_row(input logic wr, input logic [vdu_pkg::METRIC_W-1:0] m,
                                       input int a, input int b, input logic last,
                                       input logic known,
                                       input logic [vdu_pkg::SUM_W-1:0] want_dist,
                                       input logic sat);
    stim_row_t r;
    r.wr_metric        = wr;
    r.metric           = m;
    r.pair.a_elem      = 16'(a);
    r.pair.b_elem      = 16'(b);
    r.pair.last        = last;
    r.known            = known;
    r.want.distance    = want_dist;
    r.want.saturated   = sat;
    return r;
  endfunction

  function automatic logic signed [vdu_pkg::ELEM_FIELD_W-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      3, 4:    return 16'($urandom_range(510)) - 16'sd255;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one pair after an optional random gap; hold it until the transfer, then predict.
  // Valid stays high on return, so any pause must drop it at the next falling edge.
  task automatic offer_pair(input vdu_pkg::vdu_in_t item, input logic known,
                            input vdu_pkg::vdu_out_t want);
    int                gap;
    vdu_pkg::vdu_out_t res;
    gap = 0;
    while (send_idle_pct != 0 && gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (fold_pair(item, res)) pending_results.push_back(known ? want : res);
  endtask

  // Drop valid, wait until every expected result is back, then let the back stage settle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_metric(input logic [vdu_pkg::METRIC_W-1:0] m);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we   <= 1'b0;
    metric_now = m;
  endtask

  // Receiver: a requested hold-off wins; otherwise stall at the phase's rate.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    vdu_pkg::vdu_out_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, got distance %0d saturated %0b",
                 $time, out_data.distance, out_data.saturated);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.distance !== exp_res.distance) begin
          mismatches++;
          $display("%0t distance mismatch: expected %0d got %0d",
                   $time, exp_res.distance, out_data.distance);
        end
        if (out_data.saturated !== exp_res.saturated) begin
          mismatches++;
          $display("%0t saturated mismatch: expected %0b got %0b",
                   $time, exp_res.saturated, out_data.saturated);
        end
      end
    end
  end

  initial begin
    #TIMEOUT;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t                    rows[$];
    vdu_pkg::vdu_in_t             item;
    vdu_pkg::vdu_out_t            want;
    int                           sent;
    int                           len;
    int                           pick;
    logic [vdu_pkg::METRIC_W-1:0] phase_metric[4];
    int                           idle_send[4];
    int                           idle_recv[4];

    phase_metric = '{vdu_pkg::METRIC_MANHATTAN, vdu_pkg::METRIC_EUCLID,
                     vdu_pkg::METRIC_SQ_EUCLID, METRIC_UNUSED};
    idle_send    = '{0, 75, 0, 27};
    idle_recv    = '{0, 0, 75, 27};

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = vdu_pkg::METRIC_MANHATTAN;
    metric_now = vdu_pkg::METRIC_MANHATTAN;
    acc_sum   = '0;
    acc_ovf   = 1'b0;
    want      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every metric, the spare code, multi-pair and single-pair
    // vectors, and a metric change in the middle of a vector.
    rows.push_back(mk_row(0, vdu_pkg::METRIC_MANHATTAN, 0, 0, 1, 1, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_MANHATTAN, 32767, -32768, 1, 1, 48'd65535, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_MANHATTAN, -32768, 32767, 1, 1, 48'd65535, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_MANHATTAN, 100, -50, 0, 0, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_MANHATTAN, -7, 3, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(1, vdu_pkg::METRIC_SQ_EUCLID, 32767, -32768, 1, 1,
                          48'd4294836225, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_SQ_EUCLID, -32768, -32768, 1, 1, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_SQ_EUCLID, -1, 1, 0, 0, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_SQ_EUCLID, 5, -5, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(1, vdu_pkg::METRIC_EUCLID, 32767, -32768, 1, 1, 48'd65535, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_EUCLID, 3, -1, 0, 0, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_EUCLID, 0, 3, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(0, vdu_pkg::METRIC_EUCLID, 1, 0, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(1, METRIC_UNUSED, 1, -1, 0, 0, 48'd0, 0));
    rows.push_back(mk_row(0, METRIC_UNUSED, -32768, 32767, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(1, vdu_pkg::METRIC_MANHATTAN, 10, 0, 0, 0, 48'd0, 0));
    rows.push_back(mk_row(1, vdu_pkg::METRIC_EUCLID, 3, 0, 1, 0, 48'd0, 0));
    rows.push_back(mk_row(1, vdu_pkg::METRIC_SQ_EUCLID, 0, -1, 1, 0, 48'd0, 0));

    foreach (rows[i]) begin
      if (rows[i].wr_metric) begin
        quiesce();
        write_metric(rows[i].metric);
      end
      offer_pair(rows[i].pair, rows[i].known, rows[i].want);
    end

    // Back-pressure: hold the receiver off while single-pair root vectors keep coming,
    // so the job queue fills and the input stalls.
    quiesce();
    write_metric(vdu_pkg::METRIC_EUCLID);
    hold_req = ~hold_req;
    for (int k = 0; k < HOLD_VECTORS; k++) begin
      item.a_elem = rand_elem();
      item.b_elem = rand_elem();
      item.last   = 1'b1;
      offer_pair(item, 1'b0, want);
    end

    // Random vectors: mostly short, some long, up to 320 pairs.
    for (int ph = 0; ph < 8; ph++) begin
      quiesce();
      write_metric(phase_metric[ph % 4]);
      send_idle_pct = idle_send[(ph / 2) % 4];
      stall_pct     = idle_recv[(ph / 2) % 4];
      sent = 0;
      while (sent < PHASE_PAIRS) begin
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(8, 1);
        else if (pick < 95) len = $urandom_range(64, 9);
        else if (pick < 99) len = $urandom_range(256, 65);
        else                len = $urandom_range(320, 257);
        for (int k = 0; k < len; k++) begin
          item.a_elem = rand_elem();
          item.b_elem = rand_elem();
          item.last   = (k == len - 1);
          offer_pair(item, 1'b0, want);
        end
        sent += len;
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* vector_distance_unit.f */
rtl/core/vdu_pkg.sv
rtl/core/vdu_front.sv
rtl/core/vdu_queue.sv
rtl/core/vdu_back.sv
rtl/core/vector_distance_unit.sv
dv/testbench.sv
